@@ rtl/c2d_pkg.sv @@
// Shared types, widths and register indexes for the 3x3 edge-clamped convolution.
`timescale 1ns / 1ps
`default_nettype none
package c2d_pkg;

    // Fixed field widths of the streaming and configuration interfaces.
    localparam int PIX_W      = 8;
    localparam int COEFF_W    = 16;
    localparam int KSIZE      = 3;
    localparam int DIM_CFG_W  = 11;
    localparam int OUT_W      = 28;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = KSIZE * COEFF_W;
    localparam int PROD_W     = COEFF_W + PIX_W + 1;

    // Default sizes of the line stores and the frame.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_TOP = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_MID = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEFF_BOT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT    = 3'd4;

    // Request kinds carried on the slave tuser bit.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0]                      pix_t;
    typedef pix_t [KSIZE-1:0]                      win_row_t;
    typedef win_row_t [KSIZE-1:0]                  win_t;
    typedef logic [KSIZE-1:0][COEFF_W-1:0]         coeff_row_t;
    typedef logic signed [PROD_W-1:0]              prod_t;
    typedef prod_t [KSIZE-1:0][KSIZE-1:0]          prod_grid_t;
    typedef logic signed [OUT_W-1:0]               sum_t;
    typedef sum_t [KSIZE-1:0]                      row_sums_t;
    typedef logic [DIM_CFG_W-1:0]                  dim_cfg_t;

    // Reset values of the configuration registers: identity kernel, 1024 x 1024 frame.
    localparam coeff_row_t COEFF_TOP_RST = '0;
    localparam coeff_row_t COEFF_MID_RST = coeff_row_t'(48'h0000_0001_0000);
    localparam coeff_row_t COEFF_BOT_RST = '0;
    localparam dim_cfg_t   WIDTH_RST     = dim_cfg_t'(1024);
    localparam dim_cfg_t   HEIGHT_RST    = dim_cfg_t'(1024);

endpackage
`default_nettype wire

@@ rtl/conv2d_3x3_edge_clamp.sv @@
// Streaming 3x3 convolution with replicated image borders.
//
// Pixels enter on the slave stream in raster order, one request per pixel, with
// tuser low. Each result is the signed 3x3 weighted sum of one output pixel, sent on
// the master stream with tlast marking the last pixel of a row and tuser marking
// the last pixel of the frame. Results for row r leave while row r+1 streams in,
// one column behind; the first row yields nothing. After the last row, one flush
// request per column (tuser high) releases the bottom row. Requests of the wrong
// kind for the current phase are taken and dropped.
// Throughput: one request per clock unless a stalled receiver backs the pipeline up.
// The last column of a row releases two results; the second waits in a one-entry
// holding register while the next request, which releases nothing, moves up, so the
// slave side never pauses for it. A result passes stages 1, 2, P and R and the output
// register. A stalled receiver fills the pipeline and holding registers and then
// deasserts s_tready; nothing is lost or repeated. Reset (aresetn low, synchronous)
// empties the pipeline, clears the counters and window, and restores the identity
// kernel and a 1024 x 1024 frame. Line stores need no clearing pass. The user must
// write configuration through cfg_wr_en/cfg_addr/cfg_wr_data only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_3x3_edge_clamp #(
    parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [c2d_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [c2d_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [c2d_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
    input  wire logic                           s_tuser,   // [0] op (flush tick when high)
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [c2d_pkg::M_TDATA_W-1:0]       m_tdata,   // [27:0] filtered, [31:28] zero
    output logic                                m_tlast,   // row_end
    output logic [0:0]                          m_tuser    // [0] frame_end
);
    import c2d_pkg::*;

    // Column index width, width/height counts that can hold the maximum itself.
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    coeff_row_t coeff_reg [KSIZE];
    dim_cfg_t   width_reg;
    dim_cfg_t   height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg[0] <= COEFF_TOP_RST;
            coeff_reg[1] <= COEFF_MID_RST;
            coeff_reg[2] <= COEFF_BOT_RST;
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COEFF_TOP: coeff_reg[0] <= coeff_row_t'(cfg_wr_data);
                REG_COEFF_MID: coeff_reg[1] <= coeff_row_t'(cfg_wr_data);
                REG_COEFF_BOT: coeff_reg[2] <= coeff_row_t'(cfg_wr_data);
                REG_WIDTH:     width_reg    <= cfg_wr_data[DIM_CFG_W-1:0];
                REG_HEIGHT:    height_reg   <= cfg_wr_data[DIM_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A size of zero acts as one; a size beyond the store saturates to the maximum.
    logic [WW-1:0] width_eff;
    logic [RW-1:0] height_eff;

    always_comb begin
        if (width_reg == '0) begin
            width_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            height_eff = RW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            height_eff = RW'(MAX_HEIGHT);
        end else begin
            height_eff = RW'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain, from the output register back to the input.
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic r_valid_reg;
    logic p_valid_reg;
    logic s2_a_reg;
    logic s2_b_reg;
    logic hold_b_reg;
    logic s1_valid_reg;

    logic out_ready;
    logic r_ready;
    logic p_ready;
    logic s2_issue;
    logic s2_ready;
    logic move_b;
    logic s1_adv;
    logic s_accept;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign r_ready   = !r_valid_reg || out_ready;
    assign p_ready   = !p_valid_reg || r_ready;
    // The held row-end result goes first, then whatever the issue stage has.
    assign s2_issue  = (hold_b_reg || s2_a_reg || s2_b_reg) && p_ready;
    // With both results pending, the row-end one moves to the holding register
    // as the other one issues, so the issue stage empties in the same cycle.
    assign move_b    = s2_a_reg && s2_b_reg && !hold_b_reg && p_ready;
    assign s2_ready  = !(s2_a_reg || s2_b_reg) || (p_ready && !hold_b_reg);
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s_tready  = !s1_valid_reg || s2_ready;
    assign s_accept  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Position counters, evaluated for the request at the slave port.
    // ------------------------------------------------------------------
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic          at_last_col;
    logic          flushing;
    logic          item_ok;

    assign at_last_col = (WW'(col_cnt_reg) + WW'(1)) >= width_eff;
    assign flushing    = row_cnt_reg >= height_eff;
    assign item_ok     = flushing ? (s_tuser == OP_FLUSH) : (s_tuser == OP_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_accept && item_ok) begin
            if (at_last_col) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= flushing ? '0 : row_cnt_reg + RW'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores: read when a request is taken, written when a pixel request leaves stage 1.
    // ------------------------------------------------------------------
    pix_t older_mem [MAX_WIDTH];
    pix_t newer_mem [MAX_WIDTH];
    pix_t older_rd_reg;
    pix_t newer_rd_reg;

    logic          mem_we;
    pix_t          older_wdata;
    pix_t          newer_wdata;
    logic [CW-1:0] s1_addr_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            older_mem[s1_addr_reg] <= older_wdata;
            newer_mem[s1_addr_reg] <= newer_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            older_rd_reg <= older_mem[col_cnt_reg];
            newer_rd_reg <= newer_mem[col_cnt_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store data, window update, store write-back.
    // ------------------------------------------------------------------
    logic s1_row0_reg;
    logic s1_flush_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    pix_t s1_pix_reg;
    logic s1_fwd_reg;
    pix_t s1_fwd_older_reg;
    pix_t s1_fwd_newer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= item_ok;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // With a one-pixel row the same entry is read while it is still being written,
    // so the write data of the request ahead is carried along instead.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_row0_reg      <= (row_cnt_reg == '0);
            s1_flush_reg     <= flushing;
            s1_first_reg     <= (col_cnt_reg == '0);
            s1_last_reg      <= at_last_col;
            s1_pix_reg       <= s_tdata;
            s1_addr_reg      <= col_cnt_reg;
            s1_fwd_reg       <= mem_we && (s1_addr_reg == col_cnt_reg);
            s1_fwd_older_reg <= older_wdata;
            s1_fwd_newer_reg <= newer_wdata;
        end
    end

    pix_t     top_pix;
    pix_t     mid_pix;
    pix_t     bot_pix;
    win_row_t col_in;
    win_t     window_reg;
    win_t     window_next;

    assign top_pix = s1_fwd_reg ? s1_fwd_older_reg : older_rd_reg;
    assign mid_pix = s1_fwd_reg ? s1_fwd_newer_reg : newer_rd_reg;
    // Below the last row, the last row repeats.
    assign bot_pix = s1_flush_reg ? mid_pix : s1_pix_reg;

    // The first row goes into both stores so that it also serves as the row above.
    assign mem_we      = s1_adv && !s1_flush_reg;
    assign older_wdata = s1_row0_reg ? s1_pix_reg : mid_pix;
    assign newer_wdata = s1_pix_reg;

    always_comb begin
        col_in[0] = top_pix;
        col_in[1] = mid_pix;
        col_in[2] = bot_pix;
        for (int r = 0; r < KSIZE; r++) begin
            if (s1_first_reg) begin
                // Left border: the first column is replicated.
                window_next[r][0] = col_in[r];
                window_next[r][1] = col_in[r];
            end else begin
                window_next[r][0] = window_reg[r][1];
                window_next[r][1] = window_reg[r][2];
            end
            window_next[r][2] = col_in[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
        end else if (s1_adv && !s1_row0_reg) begin
            window_reg <= window_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: holds a window copy and issues up to two results, one per cycle while P is ready.
    // Result A is the column one behind the input; result B, on the last column,
    // is the last column itself with its right neighbor clamped. When both are
    // pending, B waits in the holding register while A issues.
    // ------------------------------------------------------------------
    win_t s2_win_reg;
    logic s2_frame_reg;
    win_t hold_win_reg;
    logic hold_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_a_reg <= 1'b0;
            s2_b_reg <= 1'b0;
        end else if (s1_adv) begin
            s2_a_reg <= !s1_row0_reg && !s1_first_reg;
            s2_b_reg <= !s1_row0_reg && s1_last_reg;
        end else if (p_ready && !hold_b_reg) begin
            s2_a_reg <= 1'b0;
            s2_b_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_win_reg   <= window_next;
            s2_frame_reg <= s1_flush_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_b_reg <= 1'b0;
        end else if (move_b) begin
            hold_b_reg <= 1'b1;
        end else if (p_ready) begin
            hold_b_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move_b) begin
            hold_win_reg   <= s2_win_reg;
            hold_frame_reg <= s2_frame_reg;
        end
    end

    logic issue_b;
    win_t iss_win;
    logic iss_frame;
    assign issue_b   = hold_b_reg || !s2_a_reg;
    assign iss_win   = hold_b_reg ? hold_win_reg : s2_win_reg;
    assign iss_frame = hold_b_reg ? hold_frame_reg : s2_frame_reg;

    // ------------------------------------------------------------------
    // Stage P: nine products.
    // ------------------------------------------------------------------
    prod_grid_t prod_next;
    prod_grid_t prod_reg;
    logic       p_row_end_reg;
    logic       p_frame_end_reg;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int j = 0; j < KSIZE; j++) begin
                pix_t tap;
                if (issue_b) begin
                    tap = (j == 0) ? iss_win[r][1] : iss_win[r][2];
                end else begin
                    tap = iss_win[r][j];
                end
                prod_next[r][j] = $signed(coeff_reg[r][j]) * $signed({1'b0, tap});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= s2_issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_issue) begin
            prod_reg        <= prod_next;
            p_row_end_reg   <= issue_b;
            p_frame_end_reg <= issue_b && iss_frame;
        end
    end

    // ------------------------------------------------------------------
    // Stage R: one sum per kernel row.
    // ------------------------------------------------------------------
    row_sums_t row_sum_reg;
    logic      r_row_end_reg;
    logic      r_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_ready) begin
            r_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_valid_reg && r_ready) begin
            for (int r = 0; r < KSIZE; r++) begin
                row_sum_reg[r] <= OUT_W'(prod_reg[r][0]) + OUT_W'(prod_reg[r][1])
                                + OUT_W'(prod_reg[r][2]);
            end
            r_row_end_reg   <= p_row_end_reg;
            r_frame_end_reg <= p_frame_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    sum_t out_sum_reg;
    logic out_row_end_reg;
    logic out_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_valid_reg && out_ready) begin
            out_sum_reg       <= row_sum_reg[0] + row_sum_reg[1] + row_sum_reg[2];
            out_row_end_reg   <= r_row_end_reg;
            out_frame_end_reg <= r_frame_end_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {{(M_TDATA_W - OUT_W){1'b0}}, out_sum_reg};
    assign m_tlast    = out_row_end_reg;
    assign m_tuser[0] = out_frame_end_reg;

`ifndef SYNTHESIS
    // The frame ends only on the last pixel of a row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end flagged on a result that does not end a row");

    // The row counter never passes the largest frame height.
    assert property (@(posedge aclk) disable iff (!aresetn)
        row_cnt_reg <= RW'(MAX_HEIGHT))
        else $error("row counter beyond the maximum height");

    // When both results are pending and the first issues, the second is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_a_reg && s2_b_reg && p_ready && !hold_b_reg |=> hold_b_reg)
        else $error("row-end result lost in the issue stage");
`endif

endmodule
`default_nettype wire

@@ sim/conv2d_result_checker.sv @@
// Checker that predicts and compares the result stream of the 3x3 edge-clamped convolution.
`timescale 1ns / 1ps
module conv2d_result_checker
    import c2d_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
    input  logic                  s_tuser,   // [0] op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [27:0] filtered, [31:28] zero
    input  logic                  m_tlast,   // row_end
    input  logic [0:0]            m_tuser,   // [0] frame_end
    output int                    errors,
    output int                    pending
);

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int REPORT_LIMIT = 100;

    typedef struct {
        sum_t filtered;
        logic row_end;
        logic frame_end;
    } pixel_result_t;

    pixel_result_t expected_pixels [$];
    pixel_result_t oldest;
    coeff_row_t    kernel_rows [KSIZE];
    dim_cfg_t      img_width;
    dim_cfg_t      img_height;
    pix_t          older_row [MAX_W];
    pix_t          newer_row [MAX_W];
    pix_t          win [KSIZE][KSIZE];
    int            col_count;
    int            row_count;
    int            error_tally;

    function automatic int clamp_dim(input int value, input int limit);
        return (value < 1) ? 1 : (value > limit) ? limit : value;
    endfunction

    // Weighted sum of the window, taking the given window column for each kernel column.
    function automatic sum_t window_sum(input int lc, input int cc, input int rc);
        longint acc;
        int     pick [KSIZE];
        acc  = 0;
        pick = '{lc, cc, rc};
        for (int r = 0; r < KSIZE; r++)
            for (int j = 0; j < KSIZE; j++)
                acc += longint'($signed(kernel_rows[r][j])) * longint'(win[r][pick[j]]);
        return sum_t'(acc);
    endfunction

    // Advances the line stores and window by one request and queues the results it releases.
    function automatic void convolve_request(input logic op, input pix_t px);
        int   w;
        int   h;
        int   c;
        logic last;
        logic flushing;
        pix_t taps [KSIZE];
        w        = clamp_dim(int'(img_width), MAX_W);
        h        = clamp_dim(int'(img_height), MAX_H);
        c        = col_count % MAX_W;
        last     = (c + 1 >= w);
        flushing = (row_count >= h);
        if (op != (flushing ? OP_FLUSH : OP_PIXEL))
            return;
        if (!flushing && row_count == 0) begin
            older_row[c] = px;
            newer_row[c] = px;
        end else begin
            taps[0] = older_row[c];
            taps[1] = newer_row[c];
            taps[2] = flushing ? newer_row[c] : px;
            if (!flushing) begin
                older_row[c] = taps[1];
                newer_row[c] = px;
            end
            for (int r = 0; r < KSIZE; r++) begin
                if (c == 0) begin
                    win[r][0] = taps[r];
                    win[r][1] = taps[r];
                end else begin
                    win[r][0] = win[r][1];
                    win[r][1] = win[r][2];
                end
                win[r][2] = taps[r];
            end
            if (c > 0)
                expected_pixels.push_back('{window_sum(0, 1, 2), 1'b0, 1'b0});
            if (last)
                expected_pixels.push_back('{window_sum(1, 2, 2), 1'b1, flushing});
        end
        if (last) begin
            col_count = 0;
            row_count = flushing ? 0 : row_count + 1;
        end else begin
            col_count = c + 1;
        end
    endfunction

    function automatic void flag_mismatch(input string field, input longint want,
                                          input longint got);
        error_tally++;
        if (error_tally <= REPORT_LIMIT)
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            kernel_rows[0] = COEFF_TOP_RST;
            kernel_rows[1] = COEFF_MID_RST;
            kernel_rows[2] = COEFF_BOT_RST;
            img_width      = WIDTH_RST;
            img_height     = HEIGHT_RST;
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (win[r, j])
                win[r][j] = '0;
            col_count   = 0;
            row_count   = 0;
            error_tally = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_COEFF_TOP: kernel_rows[0] = cfg_wr_data;
                    REG_COEFF_MID: kernel_rows[1] = cfg_wr_data;
                    REG_COEFF_BOT: kernel_rows[2] = cfg_wr_data;
                    REG_WIDTH:     img_width  = cfg_wr_data[DIM_CFG_W-1:0];
                    REG_HEIGHT:    img_height = cfg_wr_data[DIM_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                convolve_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    error_tally++;
                    if (error_tally <= REPORT_LIMIT)
                        $display("%0t: no result expected, got filtered %0d", $time,
                                 $signed(m_tdata[OUT_W-1:0]));
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (m_tdata[OUT_W-1:0] !== oldest.filtered)
                        flag_mismatch("filtered", oldest.filtered,
                                      $signed(m_tdata[OUT_W-1:0]));
                    if (m_tdata[M_TDATA_W-1:OUT_W] !== '0)
                        flag_mismatch("tdata padding", 0, m_tdata[M_TDATA_W-1:OUT_W]);
                    if (m_tlast !== oldest.row_end)
                        flag_mismatch("row end", oldest.row_end, m_tlast);
                    if (m_tuser[0] !== oldest.frame_end)
                        flag_mismatch("frame end", oldest.frame_end, m_tuser[0]);
                end
            end
        end
        // Registered so that the stimulus sees a settled value at every edge.
        errors  <= error_tally;
        pending <= expected_pixels.size();
    end

endmodule

@@ sim/testbench.sv @@
// Simulation top: stimulus, flow control and verdict for the 3x3 edge-clamped convolution.
`timescale 1ns / 1ps
module testbench;
    import c2d_pkg::*;

    localparam int MAX_W           = MAX_WIDTH_DEF;
    localparam int MAX_H           = MAX_HEIGHT_DEF;
    // Pause after the last expected result before touching registers, so that the block's
    // pipeline also runs empty of requests that release nothing.
    localparam int DRAIN_CYCLES    = 10;
    // Length of the one long receiver hold-off that backs the block up.
    localparam int LONG_HOLD       = 300;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int CYCLE_LIMIT     = 200000;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    pix_t                  s_tdata     = '0;   // [7:0] pixel
    logic                  s_tuser     = 1'b0; // [0] op
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // [27:0] filtered, [31:28] zero
    logic                  m_tlast;            // row_end
    logic [0:0]            m_tuser;            // [0] frame_end

    int         errors;
    int         pending;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_requests  = 0;
    int         holds_served   = 0;
    int         hold_left      = 0;
    int         good_requests  = 0;
    int         phase_start    = 0;
    int         cycle_count    = 0;
    coeff_row_t kernel [KSIZE];

    always #5 aclk = ~aclk;

    conv2d_3x3_edge_clamp dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // The checker sees every handshake and configuration write on its own and
    // reports back only the number of failures and the results still owed.
    conv2d_result_checker result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .errors     (errors),
        .pending    (pending)
    );

    // Receiver. A pending hold-off request takes priority and keeps tready low for the
    // whole LONG_HOLD hold-off, counted here; otherwise tready stalls at the phase's rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (holds_served < hold_requests) begin
            m_tready     <= 1'b0;
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int fit_dim(input int value, input int limit);
        return (value < 1) ? 1 : (value > limit) ? limit : value;
    endfunction

    // Offers one request, after a random number of idle cycles, and returns at the
    // edge where it is accepted. tvalid stays high when the next request follows.
    task automatic push_request(input logic op, input pix_t px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stops offering, waits until every expected result has been taken, then lets
    // the pipeline run empty so that a register write lands on an idle block.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Each write holds cfg_wr_en for one edge and clears it again before it returns,
    // so back-to-back writes never assign the enable twice in the same step.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One complete frame with the current kernel: all pixel rows, then one flush
    // request per column. Wrong-kind requests (a flush among pixel rows or a pixel
    // among the flushes) are mixed in at noise_pct and should be dropped silently.
    task automatic run_frame(input int w_reg, input int h_reg, input int noise_pct);
        int w;
        int h;
        settle();
        write_reg(REG_COEFF_TOP, kernel[0]);
        write_reg(REG_COEFF_MID, kernel[1]);
        write_reg(REG_COEFF_BOT, kernel[2]);
        write_reg(REG_WIDTH, CFG_DATA_W'(w_reg));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h_reg));
        w = fit_dim(w_reg, MAX_W);
        h = fit_dim(h_reg, MAX_H);
        for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_request(OP_FLUSH, pix_t'($urandom));
            push_request(OP_PIXEL, pix_t'($urandom));
        end
        for (int i = 0; i < w; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                push_request(OP_PIXEL, pix_t'($urandom));
            push_request(OP_FLUSH, pix_t'($urandom));
        end
        good_requests += (h + 1) * w;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling on either side.
        // A single-column frame (a width of zero acts as one) with the identity kernel
        // left by reset: every request after the first returns exactly one result, and the
        // first row is duplicated above itself.
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, CFG_DATA_W'(3));
        push_request(OP_PIXEL, 8'h00);
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_PIXEL, 8'h5A);
        push_request(OP_FLUSH, 8'hA5);

        // Largest positive and negative coefficients against pixels at both ends,
        // with one misplaced request of each kind.
        settle();
        kernel[0] = 48'h7FFF_7FFF_7FFF;
        kernel[1] = 48'h8000_8000_8000;
        kernel[2] = 48'h7FFF_0000_8000;
        write_reg(REG_COEFF_TOP, kernel[0]);
        write_reg(REG_COEFF_MID, kernel[1]);
        write_reg(REG_COEFF_BOT, kernel[2]);
        write_reg(REG_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_HEIGHT, CFG_DATA_W'(2));
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_PIXEL, 8'h00);
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_FLUSH, 8'h00);
        push_request(OP_PIXEL, 8'h00);
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_PIXEL, 8'h80);
        push_request(OP_PIXEL, 8'hFF);
        push_request(OP_FLUSH, 8'hFF);
        push_request(OP_FLUSH, 8'h00);
        push_request(OP_FLUSH, 8'h55);

        // Shrinking the frame in the middle of a row: the column already reached
        // counts as the last one, and the row reached starts the flush phase.
        settle();
        write_reg(REG_WIDTH, CFG_DATA_W'(4));
        write_reg(REG_HEIGHT, CFG_DATA_W'(4));
        repeat (10) push_request(OP_PIXEL, pix_t'($urandom));
        settle();
        write_reg(REG_WIDTH, CFG_DATA_W'(2));
        write_reg(REG_HEIGHT, CFG_DATA_W'(2));
        push_request(OP_FLUSH, 8'h00);

        // Random part in four flow-control phases: free running, sparse sender,
        // heavily stalled receiver, and light idling on both sides.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 84;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 84;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            if (phase == 0) begin
                // An oversized width saturates to the line store depth, so a short
                // first row does not end early; shrinking the width then closes the
                // row, and a height of one starts the flush phase right after it.
                settle();
                write_reg(REG_WIDTH, CFG_DATA_W'(2047));
                write_reg(REG_HEIGHT, CFG_DATA_W'(2047));
                repeat (6) push_request(OP_PIXEL, pix_t'($urandom));
                settle();
                write_reg(REG_WIDTH, CFG_DATA_W'(5));
                write_reg(REG_HEIGHT, CFG_DATA_W'(1));
                push_request(OP_PIXEL, pix_t'($urandom));
                repeat (5) push_request(OP_FLUSH, pix_t'($urandom));
                // Long receiver hold-off while the sender keeps offering, so the
                // result pipeline fills and s_tready must drop.
                settle();
                hold_requests++;
                run_frame(16, 6, 5);
            end
            if (phase == 3) begin
                // An oversized height keeps a one-column frame in its pixel rows
                // until the height is cut back below the row reached.
                settle();
                write_reg(REG_WIDTH, CFG_DATA_W'(1));
                write_reg(REG_HEIGHT, CFG_DATA_W'(2047));
                repeat (5) push_request(OP_PIXEL, pix_t'($urandom));
                settle();
                write_reg(REG_HEIGHT, CFG_DATA_W'(3));
                push_request(OP_FLUSH, pix_t'($urandom));
            end
            phase_start = good_requests;
            while (good_requests - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 1) == 1)
                    foreach (kernel[k])
                        kernel[k] = coeff_row_t'({$urandom, $urandom});
                run_frame(($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(0, 16),
                          $urandom_range(0, 6), 5);
            end
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
